### sv/utf8_emoji_filter_macros.svh
// ----------------------------------------------------------------------------
// utf8_emoji_filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_EMOJI_FILTER_MACROS_SVH
`define UTF8_EMOJI_FILTER_MACROS_SVH

// same-cycle implication
`define UEF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uef assertion failed");

// next-cycle implication
`define UEF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uef assertion failed");

`endif

### sv/uef_pkg.sv
// ----------------------------------------------------------------------------
// uef_pkg
// Types, code point ranges and decode functions of the emoji filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uef_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [20:0] cp_t;
	typedef logic [2:0]  count_t;
	typedef logic [1:0]  slot_t;

	localparam int unsigned NumRanges = 6;

	localparam cp_t DROP_LO [NumRanges] = '{
		21'h1F300, 21'h1F900, 21'h1F600, 21'h1F680, 21'h02600, 21'h02700
	};
	localparam cp_t DROP_HI [NumRanges] = '{
		21'h1F5FF, 21'h1F9FF, 21'h1F64F, 21'h1F6FF, 21'h026FF, 21'h027BF
	};

	// bytes of one character on their way to the output serializer
	typedef struct packed {
		byte_t [3:0] data;
		count_t      cnt;
		logic        empty;
		logic        text_end;
	} burst_t;

	function automatic count_t lead_len(input byte_t b);
		if (!b[7])
			return count_t'(1);
		else if (b[7:5] == 3'b110)
			return count_t'(2);
		else if (b[7:4] == 4'b1110)
			return count_t'(3);
		else
			return count_t'(4);
	endfunction

	function automatic logic is_cont(input byte_t b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic cp_t decode(input byte_t [3:0] b);
		if (!b[0][7])
			return {13'd0, b[0]};
		else if (b[0][7:5] == 3'b110 && is_cont(b[1]))
			return {10'd0, b[0][4:0], b[1][5:0]};
		else if (b[0][7:4] == 4'b1110 && is_cont(b[1]) && is_cont(b[2]))
			return {4'd0, b[0][4:0], b[1][5:0], b[2][5:0]};
		else
			return {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
	endfunction

	function automatic logic in_drop(input cp_t c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NumRanges; i++) begin
			if (c >= DROP_LO[i] && c <= DROP_HI[i])
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

### sv/uef_gather.sv
// ----------------------------------------------------------------------------
// uef_gather
// Input register, character assembly, decode and range test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uef_gather import uef_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  byte_t  in_byte,
	input  logic   end_of_text,
	input  logic   in_valid,
	output logic   in_stall,
	output burst_t burst,
	output logic   burst_load,
	input  logic   burst_free
);

	byte_t       byte_s1;
	logic        end_s1;
	logic        valid_s1;
	byte_t [3:0] held_q;
	slot_t       cnt_q;
	count_t      len_q;

	count_t      len_c;
	count_t      new_cnt;
	byte_t [3:0] merged;
	byte_t [3:0] masked;
	logic        complete;
	logic        done;
	logic        keep;
	count_t      nkeep;
	logic        need_slot;
	logic        go;

	always_comb begin
		len_c   = (cnt_q == '0) ? lead_len(byte_s1) : len_q;
		new_cnt = {1'b0, cnt_q} + count_t'(1);
		for (int i = 0; i < 4; i++) begin
			merged[i] = (slot_t'(i) == cnt_q) ? byte_s1 : held_q[i];
			masked[i] = (count_t'(i) < len_c) ? merged[i] : '0;
		end
		complete  = new_cnt >= len_c;
		done      = complete || end_s1;
		keep      = !complete || !in_drop(decode(masked));
		nkeep     = (done && keep) ? new_cnt : '0;
		need_slot = (nkeep != '0) || end_s1;
		go        = valid_s1 && (!need_slot || burst_free);
	end

	assign burst.data     = merged;
	assign burst.cnt      = (nkeep == '0) ? count_t'(1) : nkeep;
	assign burst.empty    = (nkeep == '0);
	assign burst.text_end = end_s1;
	assign burst_load     = go && need_slot;
	assign in_stall       = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
			len_q    <= '0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (go) begin
				cnt_q <= done ? slot_t'(0) : new_cnt[1:0];
				len_q <= done ? count_t'(0) : len_c;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			end_s1  <= end_of_text;
		end
		if (go)
			held_q[cnt_q] <= byte_s1;
	end

endmodule

### sv/uef_burst.sv
// ----------------------------------------------------------------------------
// uef_burst
// Result register that sends the bytes of one character, one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uef_burst import uef_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  burst_t burst,
	input  logic   burst_load,
	output logic   burst_free,
	output byte_t  out_byte,
	output logic   byte_valid,
	output logic   text_end,
	output logic   last_of_run,
	output logic   out_valid,
	input  logic   out_stall
);

	byte_t [3:0] data_q;
	count_t      rem_q;
	slot_t       idx_q;
	logic        empty_q;
	logic        end_q;
	logic        last;

	assign last        = (rem_q == count_t'(1));
	assign out_valid   = (rem_q != '0);
	assign burst_free  = (rem_q == '0) || (last && !out_stall);
	assign out_byte    = empty_q ? '0 : data_q[idx_q];
	assign byte_valid  = !empty_q;
	assign last_of_run = last;
	assign text_end    = end_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			idx_q   <= '0;
			empty_q <= 1'b0;
			end_q   <= 1'b0;
		end else if (burst_load) begin
			rem_q   <= burst.cnt;
			idx_q   <= '0;
			empty_q <= burst.empty;
			end_q   <= burst.text_end;
		end else if (out_valid && !out_stall) begin
			rem_q <= rem_q - count_t'(1);
			idx_q <= idx_q + slot_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (burst_load)
			data_q <= burst.data;
	end

endmodule

### sv/utf8_emoji_filter.sv
// ----------------------------------------------------------------------------
// utf8_emoji_filter
// Byte-serial UTF-8 filter that drops characters in emoji and symbol ranges.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       sink       in_valid/in_stall   in_byte, end_of_text
// out      source     out_valid/out_stall out_byte, byte_valid, text_end,
//                                         last_of_run
//
// one input byte per cycle unless in_stall; results reach the output through the
// input register and then the result register; a completed character yields up to
// four results, one per cycle from the result register unless out_stall; input
// stalls only when a kept character or a text end needs the result register before the previous one has left it
// arst_n clears all control state; held bytes carry no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_emoji_filter import uef_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  byte_t in_byte,
	input  logic  end_of_text,
	input  logic  in_valid,
	output logic  in_stall,
	output byte_t out_byte,
	output logic  byte_valid,
	output logic  text_end,
	output logic  last_of_run,
	output logic  out_valid,
	input  logic  out_stall
);

	burst_t burst;
	logic   burst_load;
	logic   burst_free;

	uef_gather u_gather (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.burst      (burst),
		.burst_load (burst_load),
		.burst_free (burst_free)
	);

	uef_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst      (burst),
		.burst_load (burst_load),
		.burst_free (burst_free),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.text_end   (text_end),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule

### sv/uef_checker.sv
// ----------------------------------------------------------------------------
// uef_checker
// Port-level checks of the emoji filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_emoji_filter_macros.svh"

module uef_checker (
	input logic       clk,
	input logic       arst_n,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       text_end,
	input logic       last_of_run,
	input logic       out_valid,
	input logic       out_stall
);

	`UEF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))
	`UEF_ASSERT_IMP(a_end_is_last, out_valid && text_end, last_of_run)
	`UEF_ASSERT_IMP(a_empty_at_end, out_valid && !byte_valid, text_end && last_of_run)
	`UEF_ASSERT_IMP(a_empty_zero, out_valid && !byte_valid, out_byte == 8'd0)

endmodule

bind utf8_emoji_filter uef_checker u_uef_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.text_end   (text_end),
	.last_of_run(last_of_run),
	.out_valid  (out_valid),
	.out_stall  (out_stall)
);

### dv/utf8_emoji_filter_checker.sv
// ----------------------------------------------------------------------------
// utf8_emoji_filter_checker
// Watches both channels of the emoji filter. Each input transfer runs through
// a local model of character gathering, decoding and range dropping, and each
// output transfer is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_emoji_filter_checker import uef_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  byte_t in_byte,
	input  logic  end_of_text,
	input  logic  in_valid,
	input  logic  in_stall,
	input  byte_t out_byte,
	input  logic  byte_valid,
	input  logic  text_end,
	input  logic  last_of_run,
	input  logic  out_valid,
	input  logic  out_stall,
	output int    mismatches,
	output int    pending,
	output int    in_xfers,
	output int    out_xfers,
	output int    drops,
	output int    cuts
);

	typedef struct packed {
		byte_t data;
		logic  valid;
		logic  tend;
		logic  last;
	} filt_res_t;

	filt_res_t expected_bytes_q[$];
	byte_t     held[4];
	count_t    held_n;
	count_t    char_len;
	int        mism_cnt;
	int        in_cnt;
	int        out_cnt;
	int        drop_cnt;
	int        cut_cnt;
	filt_res_t got;
	filt_res_t want;

	function automatic count_t len_of_lead(input byte_t b);
		casez (b)
			8'b0???????: return count_t'(1);
			8'b110?????: return count_t'(2);
			8'b1110????: return count_t'(3);
			default:     return count_t'(4);
		endcase
	endfunction

	function automatic cp_t code_point(input byte_t c0, input byte_t c1, input byte_t c2,
			input byte_t c3);
		logic k1;
		logic k2;
		k1 = (c1[7:6] == 2'b10);
		k2 = (c2[7:6] == 2'b10);
		if (!c0[7])
			return cp_t'(c0);
		if (c0[7:5] == 3'b110 && k1)
			return cp_t'({c0[4:0], c1[5:0]});
		if (c0[7:4] == 4'b1110 && k1 && k2)
			return cp_t'({c0[4:0], c1[5:0], c2[5:0]});
		return {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
	endfunction

	function automatic logic is_emoji(input cp_t c);
		return (c >= 21'h1F300 && c <= 21'h1F5FF) || (c >= 21'h1F900 && c <= 21'h1F9FF) ||
			(c >= 21'h1F600 && c <= 21'h1F64F) || (c >= 21'h1F680 && c <= 21'h1F6FF) ||
			(c >= 21'h02600 && c <= 21'h026FF) || (c >= 21'h02700 && c <= 21'h027BF);
	endfunction

	task automatic predict_filter(input byte_t b, input logic eot);
		filt_res_t run_q[$];
		filt_res_t r;
		byte_t     c[4];
		logic      keep;
		if (held_n == 0 || held_n >= 4) begin
			held_n = 0;
			char_len = len_of_lead(b);
		end
		held[held_n[1:0]] = b;
		held_n = held_n + 1'b1;
		if (held_n >= char_len || eot) begin
			keep = 1'b1;
			if (held_n >= char_len) begin
				for (int i = 0; i < 4; i++)
					c[i] = (i < int'(char_len)) ? held[i] : 8'h00;
				keep = !is_emoji(code_point(c[0], c[1], c[2], c[3]));
				if (!keep)
					drop_cnt++;
			end else begin
				cut_cnt++;
			end
			if (keep) begin
				for (int i = 0; i < int'(held_n) && i < 4; i++) begin
					r.data = held[i];
					r.valid = 1'b1;
					r.tend = 1'b0;
					r.last = 1'b0;
					run_q.push_back(r);
				end
			end
			held_n = 0;
			char_len = 0;
		end
		if (eot) begin
			if (run_q.size() == 0) begin
				r = '0;
				run_q.push_back(r);
			end
			run_q[run_q.size() - 1].tend = 1'b1;
			held_n = 0;
			char_len = 0;
		end
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i])
			expected_bytes_q.push_back(run_q[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes_q.delete();
			held_n = 0;
			char_len = 0;
			mism_cnt = 0;
			in_cnt = 0;
			out_cnt = 0;
			drop_cnt = 0;
			cut_cnt = 0;
			mismatches <= 0;
			pending <= 0;
			in_xfers <= 0;
			out_xfers <= 0;
			drops <= 0;
			cuts <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				in_cnt++;
				predict_filter(in_byte, end_of_text);
			end
			if (out_valid && !out_stall) begin
				out_cnt++;
				got = '{out_byte, byte_valid, text_end, last_of_run};
				if (expected_bytes_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("%0t: unexpected transfer, byte %02h valid %0b end %0b last %0b",
							$time, got.data, got.valid, got.tend, got.last);
				end else begin
					want = expected_bytes_q.pop_front();
					if (got != want) begin
						mism_cnt++;
						if (mism_cnt <= 10)
							$display("%0t: mismatch, expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
								$time, want.data, want.valid, want.tend, want.last,
								got.data, got.valid, got.tend, got.last);
					end
				end
			end
			mismatches <= mism_cnt;
			pending <= expected_bytes_q.size();
			in_xfers <= in_cnt;
			out_xfers <= out_cnt;
			drops <= drop_cnt;
			cuts <= cut_cnt;
		end
	end

endmodule

### dv/tb_utf8_emoji_filter.sv
// ----------------------------------------------------------------------------
// tb_utf8_emoji_filter
// Feeds the emoji filter short directed texts (range edges, bad continuation
// bytes, characters cut short, empty ends) and then random texts of mostly
// well-formed characters, with random idle gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_emoji_filter;
	import uef_pkg::*;

	typedef struct {
		byte_t b;
		logic  e;
		int    gap;
		logic  drain;
		logic  calm;
	} text_item_t;

	localparam cp_t EMO_LO [6] = '{21'h1F300, 21'h1F900, 21'h1F600, 21'h1F680, 21'h02600,
		21'h02700};
	localparam cp_t EMO_HI [6] = '{21'h1F5FF, 21'h1F9FF, 21'h1F64F, 21'h1F6FF, 21'h026FF,
		21'h027BF};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	byte_t in_byte;
	logic  end_of_text;
	logic  in_valid;
	logic  in_stall;
	byte_t out_byte;
	logic  byte_valid;
	logic  text_end;
	logic  last_of_run;
	logic  out_valid;
	logic  out_stall;
	logic  out_calm;
	int    stall_left;
	int    stall_draw;
	int    mismatches;
	int    pending;
	int    in_xfers;
	int    out_xfers;
	int    drops;
	int    cuts;

	text_item_t text_q[$];
	byte_t      chars_q[$];

	always #5 clk = ~clk;

	utf8_emoji_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.text_end   (text_end),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	utf8_emoji_filter_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.text_end   (text_end),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mismatches (mismatches),
		.pending    (pending),
		.in_xfers   (in_xfers),
		.out_xfers  (out_xfers),
		.drops      (drops),
		.cuts       (cuts)
	);

	// output side draws a stall length per transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end else if (out_valid && !out_stall) begin
			stall_draw = out_calm ? 0 : $urandom_range(0, 13);
			stall_left <= stall_draw;
			out_stall <= (stall_draw != 0);
		end
	end

	task automatic put_cp(input cp_t cp);
		if (cp < 21'h80) begin
			chars_q.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			chars_q.push_back({3'b110, cp[10:6]});
			chars_q.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			chars_q.push_back({4'b1110, cp[15:12]});
			chars_q.push_back({2'b10, cp[11:6]});
			chars_q.push_back({2'b10, cp[5:0]});
		end else begin
			chars_q.push_back({5'b11110, cp[20:18]});
			chars_q.push_back({2'b10, cp[17:12]});
			chars_q.push_back({2'b10, cp[11:6]});
			chars_q.push_back({2'b10, cp[5:0]});
		end
	endtask

	task automatic put_rand_char();
		int  k;
		int  n;
		cp_t cp;
		k = $urandom_range(0, 5);
		case ($urandom_range(0, 9))
			0, 1: put_cp(cp_t'($urandom_range(0, 'h7F)));
			2: put_cp(cp_t'($urandom_range('h80, 'h7FF)));
			3: put_cp(cp_t'($urandom_range('h800, 'hFFFF)));
			4: put_cp(cp_t'($urandom_range('h10000, 'h1FFFFF)));
			5, 6: put_cp(cp_t'($urandom_range(EMO_LO[k], EMO_HI[k])));
			7: begin
				cp = $urandom_range(0, 1) ? EMO_LO[k] : EMO_HI[k];
				put_cp(cp + cp_t'($urandom_range(0, 2)) - 21'd1);
			end
			8: chars_q.push_back(byte_t'($urandom_range(0, 255)));
			default: begin
				// multi-byte lead followed by arbitrary bytes
				chars_q.push_back(byte_t'($urandom_range('hC0, 'hFF)));
				n = $urandom_range(1, 3);
				repeat (n)
					chars_q.push_back(byte_t'($urandom_range(0, 255)));
			end
		endcase
	endtask

	task automatic flush_text(input logic drain_first);
		text_item_t it;
		logic       calm;
		calm = ($urandom_range(0, 3) == 0);
		foreach (chars_q[i]) begin
			it.b = chars_q[i];
			it.e = (i == chars_q.size() - 1);
			it.gap = calm ? 0 : $urandom_range(0, 13);
			it.drain = drain_first && (i == 0);
			it.calm = calm;
			text_q.push_back(it);
		end
		chars_q.delete();
	endtask

	task automatic put_bytes(input byte_t b0, input byte_t b1, input byte_t b2,
			input byte_t b3, input int n);
		chars_q.push_back(b0);
		if (n > 1)
			chars_q.push_back(b1);
		if (n > 2)
			chars_q.push_back(b2);
		if (n > 3)
			chars_q.push_back(b3);
	endtask

	task automatic send_item(input text_item_t it);
		if (it.gap > 0) begin
			in_valid <= 1'b0;
			repeat (it.gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= it.b;
		end_of_text <= it.e;
		out_calm <= it.calm;
		// stall is settled mid-cycle, so it tells whether the next edge takes the transfer
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int  nchar;
		int  n0;
		int  len;
		logic mid_drain;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		end_of_text <= 1'b0;
		out_calm <= 1'b0;

		// directed texts
		put_bytes(8'h00, 8'h00, 8'h00, 8'h00, 1);
		flush_text(1'b0);
		put_bytes(8'h7F, 8'h00, 8'h00, 8'h00, 1);
		put_bytes(8'hC3, 8'hA9, 8'h00, 8'h00, 2);
		put_bytes(8'hE2, 8'h98, 8'h80, 8'h00, 3);
		put_bytes(8'hE2, 8'h9F, 8'h80, 8'h00, 3);
		flush_text(1'b0);
		put_bytes(8'hF0, 8'h9F, 8'h98, 8'h80, 4);
		put_bytes(8'hF0, 8'h9F, 8'hA7, 8'hBF, 4);
		flush_text(1'b0);
		put_bytes(8'hC3, 8'h41, 8'h00, 8'h00, 2);
		flush_text(1'b0);
		put_bytes(8'hE2, 8'h98, 8'h00, 8'h00, 2);
		flush_text(1'b0);
		put_bytes(8'hFF, 8'h00, 8'h00, 8'h00, 1);
		flush_text(1'b0);
		put_bytes(8'h80, 8'hBF, 8'hFF, 8'hFE, 4);
		flush_text(1'b0);

		// random texts, occasionally cut inside the last character
		mid_drain = 1'b0;
		n0 = text_q.size();
		while (text_q.size() < n0 + 200) begin
			nchar = $urandom_range(1, 6);
			repeat (nchar) begin
				len = chars_q.size();
				put_rand_char();
			end
			len = chars_q.size() - len;
			if (len > 1 && $urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, len - 1))
					void'(chars_q.pop_back());
			end
			flush_text((text_q.size() == n0) || (!mid_drain && text_q.size() >= n0 + 100));
			if (text_q.size() >= n0 + 100)
				mid_drain = 1'b1;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (text_q[i]) begin
			if (text_q[i].drain) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			send_item(text_q[i]);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		$display("run covered %0d input transfers and %0d output transfers", in_xfers,
			out_xfers);
		$display("%0d characters dropped as emoji or symbols, %0d cut short at end of text",
			drops, cuts);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### utf8_emoji_filter.f
+incdir+sv
sv/uef_pkg.sv
sv/uef_gather.sv
sv/uef_burst.sv
sv/utf8_emoji_filter.sv
sv/uef_checker.sv
dv/utf8_emoji_filter_checker.sv
dv/tb_utf8_emoji_filter.sv
